### rtl/etfd_pkg.sv
package etfd_pkg;

   // frame layout
   localparam int FRAME_DATA_LEN = 9;
   localparam int COUNT_W        = 4;
   localparam logic [COUNT_W-1:0] LAST_DATA_SLOT = COUNT_W'(FRAME_DATA_LEN);

   // crc-8, polynomial x^8 + x^2 + x + 1, initial value 0
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] OVERRUN_DIFF = 8'hFF;

   // rpm scaling: erpm * 100 / pole pairs
   localparam int RPM_W   = 23;
   localparam int PAIRS_W = 7;
   localparam logic [RPM_W-1:0] RPM_SCALE = RPM_W'(100);
   localparam int DIV_STEPS = RPM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MOTOR_POLES = 1'b0;
   localparam logic [7:0] MOTOR_POLES_RESET = 8'd14;

   // action codes
   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_FLUSH   = 2'd1;
   localparam logic [1:0] ACT_OVERRUN = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN  = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       crc_difference;
      logic [7:0]       temperature;
      logic [15:0]      voltage;
      logic [15:0]      current;
      logic [15:0]      consumption;
      logic [RPM_W-1:0] rpm;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIVIDE,
      ST_EMIT
   } seq_state_type;

   // one byte through the crc, msb first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/esc_telemetry_frame_decoder.sv
// Telemetry frame decoder for a motor controller's serial telemetry.
// Request beats carry an action and a byte: byte received, flush or overrun.
// Ten received bytes form one frame; the tenth is the crc-8 over the first nine.
// The tenth byte yields one response beat with status, crc difference and the
// held readings; a good frame first refreshes the held readings, including
// rpm = erpm * 100 / (motor_poles / 2). An overrun yields one response beat
// with status overrun; a flush drops the partial frame silently.
// A data byte, flush or overrun needs no sequencer step. A good frame occupies
// the block after its last byte: the sequencer starts the one-bit-per-cycle
// divider, which runs 23 divide steps, then takes the quotient and loads the
// response. With fewer than two poles the divide is skipped, rpm is taken as
// zero and the response is loaded.
// A mismatch or overrun response is valid the cycle after acceptance.
// Requests are stalled while the sequencer is busy or while a response waits
// under stall; an undelivered response holds its beat until taken.
// Reset clears the frame, the held readings and the response, and sets
// motor_poles to 14. motor_poles sits at byte address 0 of the register port.
module esc_telemetry_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  etfd_pkg::req_beat_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output etfd_pkg::rsp_beat_type              rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [etfd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [etfd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [etfd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   etfd_pkg::seq_state_type state_ff, state_in;

   logic [7:0]                      motor_poles_ff, motor_poles_in;
   logic [etfd_pkg::COUNT_W-1:0]    byte_count_ff, byte_count_in;
   logic [7:0]                      running_crc_ff, running_crc_in;
   logic [7:0]                      frame_bytes_ff [etfd_pkg::FRAME_DATA_LEN];
   logic                            frame_we;
   logic [7:0]                      held_temperature_ff, held_temperature_in;
   logic [15:0]                     held_voltage_ff, held_voltage_in;
   logic [15:0]                     held_current_ff, held_current_in;
   logic [15:0]                     held_consumption_ff, held_consumption_in;
   logic [etfd_pkg::RPM_W-1:0]      held_rpm_ff, held_rpm_in;
   logic [etfd_pkg::RPM_W-1:0]      product_ff, product_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   etfd_pkg::rsp_beat_type          rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic                            csr_write;
   logic [15:0]                     erpm;
   logic [etfd_pkg::PAIRS_W-1:0]    pair_count;
   logic [7:0]                      crc_diff;
   logic                            div_start;
   logic                            div_done;
   logic [etfd_pkg::RPM_W-1:0]      div_quotient;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == etfd_pkg::REG_MOTOR_POLES) ?
                      {{(etfd_pkg::CSR_DATA_W-8){1'b0}}, motor_poles_ff} : '0;

   always_comb begin
      motor_poles_in = motor_poles_ff;
      if (csr_write && (paddr[2] == etfd_pkg::REG_MOTOR_POLES)) begin
         motor_poles_in = pwdata[7:0];
      end
   end

   // request handshake
   assign req_stall  = (state_ff != etfd_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign erpm       = {frame_bytes_ff[7], frame_bytes_ff[8]};
   assign pair_count = motor_poles_ff[7:1];
   assign crc_diff   = running_crc_ff - req_data.rx_byte;

   // sequencer: frame assembly, rpm scaling and response loading
   always_comb begin
      state_in            = state_ff;
      byte_count_in       = byte_count_ff;
      running_crc_in      = running_crc_ff;
      frame_we            = 1'b0;
      held_temperature_in = held_temperature_ff;
      held_voltage_in     = held_voltage_ff;
      held_current_in     = held_current_ff;
      held_consumption_in = held_consumption_ff;
      held_rpm_in         = held_rpm_ff;
      product_in          = product_ff;
      div_start           = 1'b0;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_data_in         = rsp_data_ff;

      case (state_ff)
         etfd_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_data.action)
                  etfd_pkg::ACT_BYTE: begin
                     if (byte_count_ff < etfd_pkg::LAST_DATA_SLOT) begin
                        frame_we       = 1'b1;
                        running_crc_in = etfd_pkg::crc8_step(running_crc_ff,
                                                             req_data.rx_byte);
                        byte_count_in  = byte_count_ff + 1'b1;
                     end else begin
                        byte_count_in  = '0;
                        running_crc_in = '0;
                        if (crc_diff == 8'd0) begin
                           held_temperature_in = frame_bytes_ff[0];
                           held_voltage_in     = {frame_bytes_ff[1], frame_bytes_ff[2]};
                           held_current_in     = {frame_bytes_ff[3], frame_bytes_ff[4]};
                           held_consumption_in = {frame_bytes_ff[5], frame_bytes_ff[6]};
                           product_in = etfd_pkg::RPM_W'({7'd0, erpm} * etfd_pkg::RPM_SCALE);
                           state_in   = etfd_pkg::ST_SCALE;
                        end else begin
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '{status:         etfd_pkg::STATUS_MISMATCH,
                                            crc_difference: crc_diff,
                                            temperature:    held_temperature_ff,
                                            voltage:        held_voltage_ff,
                                            current:        held_current_ff,
                                            consumption:    held_consumption_ff,
                                            rpm:            held_rpm_ff};
                        end
                     end
                  end
                  etfd_pkg::ACT_FLUSH: begin
                     byte_count_in  = '0;
                     running_crc_in = '0;
                  end
                  etfd_pkg::ACT_OVERRUN: begin
                     byte_count_in  = '0;
                     running_crc_in = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_data_in    = '{status:         etfd_pkg::STATUS_OVERRUN,
                                        crc_difference: etfd_pkg::OVERRUN_DIFF,
                                        temperature:    held_temperature_ff,
                                        voltage:        held_voltage_ff,
                                        current:        held_current_ff,
                                        consumption:    held_consumption_ff,
                                        rpm:            held_rpm_ff};
                  end
                  default: begin
                  end
               endcase
            end
         end
         etfd_pkg::ST_SCALE: begin
            if (pair_count == '0) begin
               held_rpm_in = '0;
               state_in    = etfd_pkg::ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = etfd_pkg::ST_DIVIDE;
            end
         end
         etfd_pkg::ST_DIVIDE: begin
            if (div_done) begin
               held_rpm_in = div_quotient;
               state_in    = etfd_pkg::ST_EMIT;
            end
         end
         etfd_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status:         etfd_pkg::STATUS_GOOD,
                             crc_difference: 8'd0,
                             temperature:    held_temperature_ff,
                             voltage:        held_voltage_ff,
                             current:        held_current_ff,
                             consumption:    held_consumption_ff,
                             rpm:            held_rpm_ff};
            state_in     = etfd_pkg::ST_IDLE;
         end
         default: begin
            state_in = etfd_pkg::ST_IDLE;
         end
      endcase
   end

   // divider for the rpm quotient
   etfd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (pair_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // frame byte store
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_bytes_ff[byte_count_ff] <= req_data.rx_byte;
      end
   end

   // control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= etfd_pkg::ST_IDLE;
         motor_poles_ff      <= etfd_pkg::MOTOR_POLES_RESET;
         byte_count_ff       <= '0;
         running_crc_ff      <= '0;
         held_temperature_ff <= '0;
         held_voltage_ff     <= '0;
         held_current_ff     <= '0;
         held_consumption_ff <= '0;
         held_rpm_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         motor_poles_ff      <= motor_poles_in;
         byte_count_ff       <= byte_count_in;
         running_crc_ff      <= running_crc_in;
         held_temperature_ff <= held_temperature_in;
         held_voltage_ff     <= held_voltage_in;
         held_current_ff     <= held_current_in;
         held_consumption_ff <= held_consumption_in;
         held_rpm_ff         <= held_rpm_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      product_ff  <= product_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/etfd_divider.sv
module etfd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [etfd_pkg::RPM_W-1:0]    dividend,
   input  logic [etfd_pkg::PAIRS_W-1:0]  divisor,
   output logic                          done,
   output logic [etfd_pkg::RPM_W-1:0]    quotient
);

   logic [etfd_pkg::RPM_W-1:0]   quo_ff, quo_in;
   logic [etfd_pkg::PAIRS_W-1:0] rem_ff, rem_in;
   logic [etfd_pkg::PAIRS_W-1:0] divisor_ff, divisor_in;
   logic [etfd_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         active_ff, active_in;
   logic [etfd_pkg::PAIRS_W:0]   shifted;
   logic [etfd_pkg::PAIRS_W:0]   trial;
   logic                         fits;

   // one restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[etfd_pkg::RPM_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      fits    = (shifted >= {1'b0, divisor_ff});
   end

   // step sequencing
   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      active_in  = active_ff;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = etfd_pkg::STEP_W'(etfd_pkg::DIV_STEPS);
         active_in  = 1'b1;
      end else if (step_ff != '0) begin
         quo_in  = {quo_ff[etfd_pkg::RPM_W-2:0], fits};
         rem_in  = fits ? trial[etfd_pkg::PAIRS_W-1:0] : shifted[etfd_pkg::PAIRS_W-1:0];
         step_in = step_ff - 1'b1;
      end else if (active_ff) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = active_ff && (step_ff == '0);
   assign quotient = quo_ff;

endmodule
